@@ rtl/c7v_pkg.sv @@
// shared types, widths and codes for the 7x1 vertical convolution unit
package c7v_pkg;

  // field widths
  localparam int ACT_W      = 2;
  localparam int CHAN_W     = 4;
  localparam int POS_W      = 5;
  localparam int TAP_W      = 3;
  localparam int DATUM_W    = 16;
  localparam int INIT_W     = 47;
  localparam int SUM_W      = 48;
  localparam int ACC_W      = SUM_W + 1;
  localparam int PROD_W     = 2 * DATUM_W;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int NCH_CFG_W  = 5;
  localparam int HT_CFG_W   = 6;

  localparam int KERNEL_TAPS = 7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd2;

  // reset values
  localparam logic [NCH_CFG_W-1:0] CHANNELS_RST = 5'd1;
  localparam logic [HT_CFG_W-1:0]  HEIGHT_RST   = 6'd32;

  // item actions
  typedef enum logic [ACT_W-1:0] {
    ACT_WEIGHT = 2'd0,
    ACT_SAMPLE = 2'd1,
    ACT_QUERY  = 2'd2
  } action_t;

  // sequencer to multiply-accumulate control
  typedef struct packed {
    logic load;   // take initial sum into the accumulator
    logic step;   // read data holds one tap to multiply in
    logic zero;   // tap reads as zero (query outside the stores)
  } mac_ctrl_t;

  // clamp the accumulator to 48-bit two's complement
  function automatic logic [SUM_W-1:0] sat_sum(input logic [ACC_W-1:0] acc);
    logic [SUM_W-1:0] res;
    if (acc[ACC_W-1] != acc[ACC_W-2]) begin
      res = acc[ACC_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      res = acc[SUM_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ rtl/conv_7x1_vertical_mac_unit.sv @@
// top level: 7x1 vertical convolution over input channels, one tap per cycle
// write words (weight or sample) are taken in one cycle; the next word follows at once
// a query walks the 7 taps of each of the N channels summed, then drains the
// product and accumulate stages; the single multiplier walks one tap per cycle
// a row error or zero channels skips the tap walk and goes straight to the done state
// synchronous active-high reset clears control and configuration; stores keep contents
module conv_7x1_vertical_mac_unit import c7v_pkg::*; #(
  parameter int MAX_IN_CHANNELS  = 16,
  parameter int MAX_OUT_CHANNELS = 16,
  parameter int MAX_HEIGHT       = 32,
  parameter int MAX_WIDTH        = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  // item channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ACT_W-1:0]          action,
  input  logic [CHAN_W-1:0]         in_chan,
  input  logic [CHAN_W-1:0]         out_chan,
  input  logic [POS_W-1:0]          row,
  input  logic [POS_W-1:0]          col,
  input  logic [TAP_W-1:0]          tap,
  input  logic signed [DATUM_W-1:0] datum,
  input  logic signed [INIT_W-1:0]  initial_sum,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [SUM_W-1:0]   sum_out,
  output logic                      row_error
);

  localparam int W_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * KERNEL_TAPS;
  localparam int I_DEPTH = MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
  localparam int WA_W    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int IA_W    = (I_DEPTH > 1) ? $clog2(I_DEPTH) : 1;

  logic [NCH_CFG_W-1:0] channels_in_use;
  logic [HT_CFG_W-1:0]  image_height;

  logic                 w_we;
  logic [WA_W-1:0]      w_waddr;
  logic [WA_W-1:0]      w_raddr;
  logic [DATUM_W-1:0]   w_rdata;
  logic                 img_we;
  logic [IA_W-1:0]      img_waddr;
  logic [IA_W-1:0]      img_raddr;
  logic [DATUM_W-1:0]   img_rdata;
  mac_ctrl_t            mac_ctrl;
  logic [ACC_W-1:0]     acc;
  logic [SUM_W-1:0]     sum_word;

  assign cfg_ready = 1'b1;

  // configuration registers; columns use a fixed stride, so width needs no storage
  always_ff @(posedge clk) begin
    if (rst) begin
      channels_in_use <= CHANNELS_RST;
      image_height    <= HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CHANNELS: channels_in_use <= cfg_data[NCH_CFG_W-1:0];
        REG_HEIGHT:   image_height    <= cfg_data[HT_CFG_W-1:0];
        REG_WIDTH: begin
        end
        default: begin
        end
      endcase
    end
  end

  c7v_seq #(
    .MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
    .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS),
    .MAX_HEIGHT       (MAX_HEIGHT),
    .MAX_WIDTH        (MAX_WIDTH)
  ) u_seq (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .action          (action),
    .in_chan         (in_chan),
    .out_chan        (out_chan),
    .row             (row),
    .col             (col),
    .tap             (tap),
    .channels_in_use (channels_in_use),
    .image_height    (image_height),
    .w_we            (w_we),
    .w_waddr         (w_waddr),
    .w_raddr         (w_raddr),
    .img_we          (img_we),
    .img_waddr       (img_waddr),
    .img_raddr       (img_raddr),
    .mac_ctrl        (mac_ctrl),
    .acc             (acc),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .sum_out         (sum_word),
    .row_error       (row_error)
  );

  assign sum_out = sum_word;

  // weight store
  c7v_ram #(
    .WIDTH (DATUM_W),
    .DEPTH (W_DEPTH)
  ) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (datum),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  // image store
  c7v_ram #(
    .WIDTH (DATUM_W),
    .DEPTH (I_DEPTH)
  ) u_image_ram (
    .clk   (clk),
    .we    (img_we),
    .waddr (img_waddr),
    .wdata (datum),
    .raddr (img_raddr),
    .rdata (img_rdata)
  );

  c7v_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (mac_ctrl),
    .init_sum (initial_sum),
    .weight   (w_rdata),
    .sample   (img_rdata),
    .acc      (acc)
  );

endmodule

@@ rtl/c7v_ram.sv @@
// generic single-write, single-read memory with registered read data
module c7v_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/c7v_mac.sv @@
// shared multiply-accumulate unit: one weight times one sample per cycle
module c7v_mac import c7v_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  mac_ctrl_t                  ctrl,
  input  logic signed [INIT_W-1:0]   init_sum,
  input  logic signed [DATUM_W-1:0]  weight,
  input  logic signed [DATUM_W-1:0]  sample,
  output logic [ACC_W-1:0]           acc
);

  logic signed [PROD_W-1:0] prod;
  logic                     pvalid;

  // product stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= 1'b0;
    end else begin
      pvalid <= ctrl.step;
    end
  end

  // product register
  always_ff @(posedge clk) begin
    if (ctrl.zero) begin
      prod <= '0;
    end else begin
      prod <= weight * sample;
    end
  end

  // accumulator, preloaded with the initial sum of the query
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc <= {{(ACC_W-INIT_W){init_sum[INIT_W-1]}}, init_sum};
    end else if (pvalid) begin
      acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

endmodule

@@ rtl/c7v_seq.sv @@
// sequencer: store writes, tap walk over input channels, result register
module c7v_seq import c7v_pkg::*; #(
  parameter int MAX_IN_CHANNELS  = 16,
  parameter int MAX_OUT_CHANNELS = 16,
  parameter int MAX_HEIGHT       = 32,
  parameter int MAX_WIDTH        = 32,
  localparam int W_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * KERNEL_TAPS,
  localparam int I_DEPTH = MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH,
  localparam int WA_W    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1,
  localparam int IA_W    = (I_DEPTH > 1) ? $clog2(I_DEPTH) : 1,
  localparam int NCH_W   = $clog2(MAX_IN_CHANNELS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  // item channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ACT_W-1:0]      action,
  input  logic [CHAN_W-1:0]     in_chan,
  input  logic [CHAN_W-1:0]     out_chan,
  input  logic [POS_W-1:0]      row,
  input  logic [POS_W-1:0]      col,
  input  logic [TAP_W-1:0]      tap,
  // configuration
  input  logic [NCH_CFG_W-1:0]  channels_in_use,
  input  logic [HT_CFG_W-1:0]   image_height,
  // store ports
  output logic                  w_we,
  output logic [WA_W-1:0]       w_waddr,
  output logic [WA_W-1:0]       w_raddr,
  output logic                  img_we,
  output logic [IA_W-1:0]       img_waddr,
  output logic [IA_W-1:0]       img_raddr,
  // multiply-accumulate unit
  output mac_ctrl_t             mac_ctrl,
  input  logic [ACC_W-1:0]      acc,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SUM_W-1:0]      sum_out,
  output logic                  row_error
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t            state;
  logic [NCH_W-1:0]  ch;
  logic [TAP_W-1:0]  tap_cnt;
  logic              drain;
  logic [CHAN_W-1:0] q_oc;
  logic [POS_W-1:0]  q_row;
  logic [POS_W-1:0]  q_col;
  logic [NCH_W-1:0]  q_nch;
  logic              q_err;
  logic              q_mask;
  logic              step_q;
  logic              zero_q;

  logic              in_acc;
  logic              is_query;
  logic [31:0]       nch_full;
  logic [NCH_W-1:0]  nch_eff;
  logic [31:0]       ht_full;
  logic              err_now;
  logic              mask_now;
  logic [31:0]       w_waddr_full;
  logic [31:0]       img_waddr_full;
  logic [31:0]       w_raddr_full;
  logic [31:0]       img_raddr_full;

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign is_query = (action == ACT_QUERY);

  // effective channel count and height, clamped to the stores; row error and mask flags
  always_comb begin
    nch_full = (32'(channels_in_use) > 32'(MAX_IN_CHANNELS)) ?
               32'(MAX_IN_CHANNELS) : 32'(channels_in_use);
    nch_eff  = nch_full[NCH_W-1:0];
    ht_full  = (32'(image_height) > 32'(MAX_HEIGHT)) ?
               32'(MAX_HEIGHT) : 32'(image_height);
    err_now  = (32'(row) + 32'(KERNEL_TAPS)) > ht_full;
    mask_now = (32'(out_chan) >= 32'(MAX_OUT_CHANNELS)) ||
               (32'(col) >= 32'(MAX_WIDTH));
  end

  // store writes, out-of-range words dropped
  always_comb begin
    w_waddr_full   = (32'(out_chan) * 32'(MAX_IN_CHANNELS) + 32'(in_chan))
                     * 32'(KERNEL_TAPS) + 32'(tap);
    img_waddr_full = (32'(in_chan) * 32'(MAX_HEIGHT) + 32'(row)) * 32'(MAX_WIDTH)
                     + 32'(col);
    w_waddr   = w_waddr_full[WA_W-1:0];
    img_waddr = img_waddr_full[IA_W-1:0];
    w_we      = in_acc && (action == ACT_WEIGHT) &&
                (32'(out_chan) < 32'(MAX_OUT_CHANNELS)) &&
                (32'(in_chan) < 32'(MAX_IN_CHANNELS)) &&
                (32'(tap) < 32'(KERNEL_TAPS));
    img_we    = in_acc && (action == ACT_SAMPLE) &&
                (32'(in_chan) < 32'(MAX_IN_CHANNELS)) &&
                (32'(row) < 32'(MAX_HEIGHT)) &&
                (32'(col) < 32'(MAX_WIDTH));
  end

  // read addresses for the current channel and tap
  always_comb begin
    w_raddr_full   = (32'(q_oc) * 32'(MAX_IN_CHANNELS) + 32'(ch)) * 32'(KERNEL_TAPS)
                     + 32'(tap_cnt);
    img_raddr_full = (32'(ch) * 32'(MAX_HEIGHT) + 32'(q_row) + 32'(tap_cnt))
                     * 32'(MAX_WIDTH) + 32'(q_col);
    w_raddr   = w_raddr_full[WA_W-1:0];
    img_raddr = img_raddr_full[IA_W-1:0];
  end

  // control to the multiply-accumulate unit, aligned with read data
  assign mac_ctrl.load = in_acc && is_query;
  assign mac_ctrl.step = step_q;
  assign mac_ctrl.zero = zero_q;

  // state, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step_q    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      step_q <= (state == ST_RUN);
      zero_q <= q_mask;
      // result word: raised when the sum is ready, dropped once taken
      if (state == ST_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc && is_query) begin
            q_oc    <= out_chan;
            q_row   <= row;
            q_col   <= col;
            q_nch   <= nch_eff;
            q_err   <= err_now;
            q_mask  <= mask_now;
            ch      <= '0;
            tap_cnt <= '0;
            drain   <= 1'b0;
            state   <= (err_now || nch_eff == '0) ? ST_DONE : ST_RUN;
          end
        end
        ST_RUN: begin
          if (tap_cnt == TAP_W'(KERNEL_TAPS - 1)) begin
            tap_cnt <= '0;
            if ((ch + NCH_W'(1)) == q_nch) begin
              state <= ST_DRAIN;
            end else begin
              ch <= ch + NCH_W'(1);
            end
          end else begin
            tap_cnt <= tap_cnt + TAP_W'(1);
          end
        end
        ST_DRAIN: begin
          // product and accumulate stages empty out
          drain <= 1'b1;
          if (drain) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            sum_out   <= q_err ? '0 : sat_sum(acc);
            row_error <= q_err;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/c7v_checker.sv @@
// port-level checks for the 7x1 vertical convolution unit, bound to the top level
module c7v_checker import c7v_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic [ACT_W-1:0]  action,
  input logic              out_valid,
  input logic              out_ready,
  input logic [SUM_W-1:0]  sum_out,
  input logic              row_error
);

  // a store write word leaves the unit ready for the next word
  a_write_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action != ACT_QUERY) |=> in_ready)
    else $error("unit not ready after a write word");

  // a query holds off further words while the taps are walked
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action == ACT_QUERY) |=> !in_ready)
    else $error("unit ready right after a query");

  // a row error result carries a zero sum
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && row_error) |-> (sum_out == '0))
    else $error("row error with nonzero sum");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(sum_out) && $stable(row_error)))
    else $error("result word changed while stalled");

endmodule

bind conv_7x1_vertical_mac_unit c7v_checker u_c7v_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .action    (action),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .sum_out   (sum_out),
  .row_error (row_error)
);

@@ bench/conv_7x1_vertical_mac_unit_checker.sv @@
// checker for the 7x1 vertical convolution unit: mirrors the stores, predicts and compares sums
`timescale 1ns / 1ps
module conv_7x1_vertical_mac_unit_checker import c7v_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [ACT_W-1:0]          action,
  input  logic [CHAN_W-1:0]         in_chan,
  input  logic [CHAN_W-1:0]         out_chan,
  input  logic [POS_W-1:0]          row,
  input  logic [POS_W-1:0]          col,
  input  logic [TAP_W-1:0]          tap,
  input  logic signed [DATUM_W-1:0] datum,
  input  logic signed [INIT_W-1:0]  initial_sum,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [SUM_W-1:0]   sum_out,
  input  logic                      row_error,
  output int                        errors,
  output int                        pending
);

  localparam int N_IN     = 16;
  localparam int N_OUT    = 16;
  localparam int IMG_ROWS = 32;
  localparam int IMG_COLS = 32;
  localparam logic signed [ACC_W-1:0] SUM_TOP = {2'b00, {(SUM_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SUM_BOT = {2'b11, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic                    row_err;
  } conv_result_t;

  // local copy of the coefficient and image stores
  logic signed [DATUM_W-1:0] coef_mem [N_OUT][N_IN][KERNEL_TAPS];
  logic signed [DATUM_W-1:0] pix_mem  [N_IN][IMG_ROWS][IMG_COLS];

  logic [NCH_CFG_W-1:0]  nch_cfg;
  logic [HT_CFG_W-1:0]   ht_cfg;

  conv_result_t sums_due [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // expected sum for one query under the current register settings
  function automatic conv_result_t conv_value(input logic [CHAN_W-1:0] oc,
                                              input logic [POS_W-1:0] r,
                                              input logic [POS_W-1:0] c,
                                              input logic signed [INIT_W-1:0] init);
    int h, nch, ic, t;
    logic signed [ACC_W-1:0] acc;
    conv_result_t res;
    h   = (ht_cfg > IMG_ROWS) ? IMG_ROWS : int'(ht_cfg);
    nch = (nch_cfg > N_IN) ? N_IN : int'(nch_cfg);
    res.sum     = '0;
    res.row_err = 1'b1;
    if (h < KERNEL_TAPS || int'(r) > h - KERNEL_TAPS) return res;
    acc = init;
    for (ic = 0; ic < nch; ic++) begin
      for (t = 0; t < KERNEL_TAPS; t++) begin
        acc = acc + coef_mem[oc][ic][t] * pix_mem[ic][r + t][c];
      end
    end
    // clamp to 48-bit two's complement
    if (acc > SUM_TOP) acc = SUM_TOP;
    else if (acc < SUM_BOT) acc = SUM_BOT;
    res.sum     = acc[SUM_W-1:0];
    res.row_err = 1'b0;
    return res;
  endfunction

  always @(posedge clk) begin
    conv_result_t due;
    if (rst) begin
      nch_cfg = CHANNELS_RST;
      ht_cfg  = HEIGHT_RST;
      sums_due.delete();
    end else begin
      // result word against the oldest expectation
      if (out_valid && out_ready) begin
        if (sums_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word: expected none, got sum %0d row_error %0b",
                   $time, sum_out, row_error);
        end else begin
          due = sums_due.pop_front();
          if (sum_out !== due.sum) begin
            errors++;
            $display("%0t: sum_out mismatch: expected %0d, got %0d", $time, due.sum, sum_out);
          end
          if (row_error !== due.row_err) begin
            errors++;
            $display("%0t: row_error mismatch: expected %0b, got %0b",
                     $time, due.row_err, row_error);
          end
        end
      end
      // input words update the stores or queue a sum
      if (in_valid && in_ready) begin
        case (action)
          ACT_WEIGHT: begin
            if (tap < KERNEL_TAPS) coef_mem[out_chan][in_chan][tap] = datum;
          end
          ACT_SAMPLE: pix_mem[in_chan][row][col] = datum;
          ACT_QUERY: sums_due.push_back(conv_value(out_chan, row, col, initial_sum));
          default: ;
        endcase
      end
      // register writes take effect for later words
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CHANNELS: nch_cfg = cfg_data[NCH_CFG_W-1:0];
          REG_HEIGHT: ht_cfg = cfg_data[HT_CFG_W-1:0];
          default: ;
        endcase
      end
    end
    pending = sums_due.size();
  end

endmodule

@@ bench/conv_7x1_vertical_mac_unit_tb.sv @@
// testbench top for the 7x1 vertical convolution unit: stimulus, reset, watchdog and verdict
`timescale 1ns / 1ps
module conv_7x1_vertical_mac_unit_tb;
  import c7v_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 400;
  localparam int SETTLE_CYCLES  = 16;
  localparam int DRAIN_CYCLES   = 130;
  localparam int N_IN           = 16;
  localparam int N_OUT          = 16;
  localparam int IMG_ROWS       = 32;
  localparam int IMG_COLS       = 32;
  localparam logic [ACT_W-1:0]     ACT_IGNORED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONE    = 2'd3;
  localparam logic signed [INIT_W-1:0] INIT_MAX = {1'b0, {(INIT_W-1){1'b1}}};
  localparam logic signed [INIT_W-1:0] INIT_MIN = {1'b1, {(INIT_W-1){1'b0}}};

  logic                      clk         = 1'b0;
  logic                      rst         = 1'b1;
  logic                      cfg_valid   = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index   = '0;
  logic [CFG_DATA_W-1:0]     cfg_data    = '0;
  logic                      in_valid    = 1'b0;
  logic                      in_ready;
  logic [ACT_W-1:0]          action      = '0;
  logic [CHAN_W-1:0]         in_chan     = '0;
  logic [CHAN_W-1:0]         out_chan    = '0;
  logic [POS_W-1:0]          row         = '0;
  logic [POS_W-1:0]          col         = '0;
  logic [TAP_W-1:0]          tap         = '0;
  logic signed [DATUM_W-1:0] datum       = '0;
  logic signed [INIT_W-1:0]  initial_sum = '0;
  logic                      out_valid;
  logic                      out_ready   = 1'b0;
  logic signed [SUM_W-1:0]   sum_out;
  logic                      row_error;
  int                        errors;
  int                        pending;

  // stimulus bookkeeping
  bit quiet   = 1'b0;
  bit hold_go = 1'b0;
  int items_sent  = 0;
  int idle_cycles = 0;
  logic [NCH_CFG_W-1:0] ch_set = CHANNELS_RST;
  logic [HT_CFG_W-1:0]  ht_set = HEIGHT_RST;
  bit wt_seen [N_OUT][N_IN][KERNEL_TAPS];
  bit px_seen [N_IN][IMG_ROWS][IMG_COLS];

  conv_7x1_vertical_mac_unit i_dut (.*);

  conv_7x1_vertical_mac_unit_checker i_checker (.*);

  always #HALF_PERIOD clk = ~clk;

  // watchdog: cycles with no word moving on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: short random stalls, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  function automatic logic signed [DATUM_W-1:0] pick_datum();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(DATUM_W-1){1'b0}}};
      1: return {1'b0, {(DATUM_W-1){1'b1}}};
      2: return '1;
      3: return '0;
      default: return DATUM_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [INIT_W-1:0] pick_init();
    case ($urandom_range(0, 9))
      0: return INIT_MAX;
      1: return INIT_MIN;
      2: return '1;
      3: return '0;
      default: return INIT_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic int eff_height();
    return (ht_set > IMG_ROWS) ? IMG_ROWS : int'(ht_set);
  endfunction

  function automatic int eff_channels();
    return (ch_set > N_IN) ? N_IN : int'(ch_set);
  endfunction

  // present one input word and hold it until taken; entered and left at a falling edge
  task automatic put_word(input logic [ACT_W-1:0] act, input logic [CHAN_W-1:0] ic,
                          input logic [CHAN_W-1:0] oc, input logic [POS_W-1:0] r,
                          input logic [POS_W-1:0] c, input logic [TAP_W-1:0] t,
                          input logic signed [DATUM_W-1:0] d,
                          input logic signed [INIT_W-1:0] init);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    action      = act;
    in_chan     = ic;
    out_chan    = oc;
    row         = r;
    col         = c;
    tap         = t;
    datum       = d;
    initial_sum = init;
    in_valid    = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (act != ACT_IGNORED) items_sent++;
  endtask

  task automatic load_weight(input logic [CHAN_W-1:0] oc, input logic [CHAN_W-1:0] ic,
                             input logic [TAP_W-1:0] t, input logic signed [DATUM_W-1:0] d);
    put_word(ACT_WEIGHT, ic, oc, POS_W'($urandom), POS_W'($urandom), t, d, pick_init());
    if (t < KERNEL_TAPS) wt_seen[oc][ic][t] = 1'b1;
  endtask

  task automatic load_pixel(input logic [CHAN_W-1:0] ic, input logic [POS_W-1:0] r,
                            input logic [POS_W-1:0] c, input logic signed [DATUM_W-1:0] d);
    put_word(ACT_SAMPLE, ic, CHAN_W'($urandom), r, c, TAP_W'($urandom), d, pick_init());
    px_seen[ic][r][c] = 1'b1;
  endtask

  // query word, preceded by writes of any entry it would read that was never written
  task automatic ask(input logic [CHAN_W-1:0] oc, input logic [POS_W-1:0] r,
                     input logic [POS_W-1:0] c, input logic signed [INIT_W-1:0] init);
    int h, nch, ic, t;
    h   = eff_height();
    nch = eff_channels();
    if (h >= KERNEL_TAPS && int'(r) <= h - KERNEL_TAPS) begin
      for (ic = 0; ic < nch; ic++) begin
        for (t = 0; t < KERNEL_TAPS; t++) begin
          if (!wt_seen[oc][ic][t]) load_weight(oc, ic, t, pick_datum());
          if (!px_seen[ic][r + t][c]) load_pixel(ic, r + t, c, pick_datum());
        end
      end
    end
    put_word(ACT_QUERY, CHAN_W'($urandom), oc, r, c, TAP_W'($urandom), pick_datum(), init);
  endtask

  // wait for every outstanding sum, then let the block go quiet
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    case (idx)
      REG_CHANNELS: ch_set = val[NCH_CFG_W-1:0];
      REG_HEIGHT: ht_set = val[HT_CFG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] nch, input logic [CFG_DATA_W-1:0] ht,
                           input logic [CFG_DATA_W-1:0] wd);
    settle();
    set_reg(REG_CHANNELS, nch);
    set_reg(REG_HEIGHT, ht);
    set_reg(REG_WIDTH, wd);
  endtask

  // random mix: mostly queries on valid rows with a few channels and columns reused
  task automatic run_phase(input int n_words);
    int stop_at, h, pick;
    logic [CHAN_W-1:0] oc;
    logic [POS_W-1:0]  r, c;
    stop_at = items_sent + n_words;
    while (items_sent < stop_at) begin
      h    = eff_height();
      pick = $urandom_range(0, 99);
      oc   = ($urandom_range(0, 3) == 0) ? CHAN_W'($urandom) : CHAN_W'($urandom_range(0, 2));
      c    = ($urandom_range(0, 3) == 0) ? POS_W'($urandom) : POS_W'($urandom_range(0, 3));
      if (h >= KERNEL_TAPS && pick < 60) r = POS_W'($urandom_range(0, h - KERNEL_TAPS));
      else r = POS_W'($urandom);
      if (pick < 70)
        ask(oc, r, c, pick_init());
      else if (pick < 82)
        load_weight(oc, CHAN_W'($urandom), TAP_W'($urandom), pick_datum());
      else if (pick < 94)
        load_pixel(CHAN_W'($urandom), POS_W'($urandom), POS_W'($urandom), pick_datum());
      else
        put_word(ACT_IGNORED, CHAN_W'($urandom), oc, r, c, TAP_W'($urandom), pick_datum(),
                 pick_init());
    end
  endtask

  initial begin
    int t;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    // directed: extreme weights and samples on the last output row and column
    for (t = 0; t < KERNEL_TAPS; t++) begin
      load_weight(CHAN_W'(N_OUT - 1), '0, TAP_W'(t),
                  t[0] ? {1'b0, {(DATUM_W-1){1'b1}}} : {1'b1, {(DATUM_W-1){1'b0}}});
    end
    for (t = 0; t < KERNEL_TAPS; t++) begin
      load_pixel('0, POS_W'(IMG_ROWS - KERNEL_TAPS + t), POS_W'(IMG_COLS - 1),
                 {1'b1, {(DATUM_W-1){1'b0}}});
    end
    ask(CHAN_W'(N_OUT - 1), POS_W'(IMG_ROWS - KERNEL_TAPS), POS_W'(IMG_COLS - 1), INIT_MAX);
    ask(CHAN_W'(N_OUT - 1), POS_W'(IMG_ROWS - KERNEL_TAPS), POS_W'(IMG_COLS - 1), INIT_MIN);
    // first row past the end, then the last row
    ask(CHAN_W'(N_OUT - 1), POS_W'(IMG_ROWS - KERNEL_TAPS + 1), POS_W'(IMG_COLS - 1), '1);
    ask('0, '1, '0, '0);
    // unknown action and a weight at tap seven are both dropped
    put_word(ACT_IGNORED, '1, '1, '1, '1, '1, '1, '1);
    load_weight('0, '0, '1, pick_datum());

    // one channel, full plane; long result hold-off, then a drain pause
    configure(6'd1, 6'd32, 6'd32);
    run_phase(100);
    hold_go = 1'b1;
    run_phase(100);
    settle();
    run_phase(100);

    // all channels, single output row
    configure(6'd16, 6'd7, 6'd1);
    run_phase(200);

    // no channels summed: sum is the initial sum
    configure(6'd0, 6'd20, 6'd5);
    run_phase(100);

    // register values beyond the stores clamp to the maximum
    configure(6'h3F, 6'h3F, 6'd0);
    run_phase(200);

    // plane shorter than the kernel: every query is a row error
    configure(6'd3, 6'd5, 6'h3F);
    run_phase(80);

    configure(6'd2, 6'd0, 6'd9);
    set_reg(REG_NONE, 6'h2A);
    run_phase(50);

    // last stretch with no idling on either side
    configure(6'd4, 6'd12, 6'd17);
    quiet = 1'b1;
    run_phase(300);

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
